@@ sv/assert_macros.svh @@
// Assertion helpers shared by the backup device RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high
`define SEB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high
`define SEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/seb_pkg.sv @@
package seb_pkg;

   // Bus phase, one-hot
   typedef enum logic [9:0] {
      PH_DESEL = 10'b00_0000_0001,
      PH_CMD   = 10'b00_0000_0010,
      PH_IDLE  = 10'b00_0000_0100,
      PH_RDSR  = 10'b00_0000_1000,
      PH_WRSR  = 10'b00_0001_0000,
      PH_ADDR0 = 10'b00_0010_0000,
      PH_ADDR1 = 10'b00_0100_0000,
      PH_ADDR2 = 10'b00_1000_0000,
      PH_READ  = 10'b01_0000_0000,
      PH_WRITE = 10'b10_0000_0000
   } phase_type;

   // Host actions
   localparam logic [1:0] ACT_XFER    = 2'd0;
   localparam logic [1:0] ACT_SELECT  = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   // Command opcodes
   localparam logic [7:0] CMD_WRSR  = 8'h01;
   localparam logic [7:0] CMD_WRITE = 8'h02;
   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_WRDI  = 8'h04;
   localparam logic [7:0] CMD_RDSR  = 8'h05;
   localparam logic [7:0] CMD_WREN  = 8'h06;

   // Size codes
   localparam logic [1:0] SIZE_8K   = 2'd0;
   localparam logic [1:0] SIZE_32K  = 2'd1;
   localparam logic [1:0] SIZE_64K  = 2'd2;
   localparam logic [1:0] SIZE_128K = 2'd3;

   // Protect modes
   localparam logic [1:0] PROT_NONE    = 2'd0;
   localparam logic [1:0] PROT_QUARTER = 2'd1;
   localparam logic [1:0] PROT_HALF    = 2'd2;
   localparam logic [1:0] PROT_ALL     = 2'd3;

   localparam logic [23:0] PROT_QUARTER_BASE = 24'h00_C000;
   localparam logic [23:0] PROT_HALF_BASE    = 24'h00_8000;

   localparam logic [7:0] IDLE_BYTE = 8'hFF;

   // Store access and response produced for one transaction
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [23:0] index;
      logic [7:0]  wdata;
      logic [7:0]  rsp_byte;
   } mem_req_type;

   function automatic logic [23:0] size_mask(input logic [1:0] code);
      logic [23:0] m;
      case (code)
         SIZE_8K:  m = 24'h00_1FFF;
         SIZE_32K: m = 24'h00_7FFF;
         SIZE_64K: m = 24'h00_FFFF;
         default:  m = 24'h01_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [23:0] wrap_mask(input logic [1:0] code);
      logic [23:0] m;
      case (code)
         SIZE_8K:  m = 24'h00_001F;
         SIZE_32K: m = 24'h00_7FFF;
         SIZE_64K: m = 24'h00_007F;
         default:  m = 24'h00_00FF;
      endcase
      return m;
   endfunction

endpackage

@@ sv/seb_if.sv @@
// Host byte channel
interface seb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink (input valid, input action, input data_byte, output ready);
endinterface

// Returned byte channel
interface seb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;

   modport source (output valid, output read_byte, input ready);
   modport sink (input valid, input read_byte, output ready);
endinterface

// Size register write channel
interface seb_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] size_code;

   modport source (output valid, output size_code, input ready);
   modport sink (input valid, input size_code, output ready);
endinterface

@@ sv/seb_cmd_ctrl.sv @@
`include "assert_macros.svh"

module seb_cmd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [1:0]          action,
   input  logic [7:0]          data_byte,
   input  logic [1:0]          size_code,
   output seb_pkg::mem_req_type mreq
);

   seb_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  last_cmd_ff, last_cmd_in;
   logic [23:0] addr_ff, addr_in;
   logic        wel_ff, wel_in;
   logic [1:0]  prot_ff, prot_in;
   logic        swd_ff, swd_in;

   logic               blocked;
   logic [23:0]        pmask;
   seb_pkg::phase_type first_addr;

   // Decide whether the current address is write protected
   always_comb begin
      unique case (prot_ff)
         seb_pkg::PROT_NONE:    blocked = 1'b0;
         seb_pkg::PROT_QUARTER: blocked = addr_ff >= seb_pkg::PROT_QUARTER_BASE;
         seb_pkg::PROT_HALF:    blocked = addr_ff >= seb_pkg::PROT_HALF_BASE;
         default:               blocked = 1'b1;
      endcase
   end

   assign pmask      = seb_pkg::wrap_mask(size_code);
   assign first_addr = (size_code == seb_pkg::SIZE_128K) ? seb_pkg::PH_ADDR0
                                                          : seb_pkg::PH_ADDR1;

   // Advance the command state for one accepted transaction
   always_comb begin
      phase_in      = phase_ff;
      last_cmd_in   = last_cmd_ff;
      addr_in       = addr_ff;
      wel_in        = wel_ff;
      prot_in       = prot_ff;
      swd_in        = swd_ff;
      mreq.rd       = 1'b0;
      mreq.wr       = 1'b0;
      mreq.index    = addr_ff & seb_pkg::size_mask(size_code);
      mreq.wdata    = data_byte;
      mreq.rsp_byte = seb_pkg::IDLE_BYTE;

      if (fire) begin
         unique case (action)
            seb_pkg::ACT_XFER: begin
               unique case (phase_ff)
                  seb_pkg::PH_CMD: begin
                     last_cmd_in = data_byte;
                     unique case (data_byte)
                        seb_pkg::CMD_WREN: begin
                           wel_in   = 1'b1;
                           phase_in = seb_pkg::PH_IDLE;
                        end
                        seb_pkg::CMD_WRDI: begin
                           wel_in   = 1'b0;
                           phase_in = seb_pkg::PH_IDLE;
                        end
                        seb_pkg::CMD_RDSR: phase_in = seb_pkg::PH_RDSR;
                        seb_pkg::CMD_WRSR: begin
                           phase_in = wel_ff ? seb_pkg::PH_WRSR : seb_pkg::PH_IDLE;
                        end
                        seb_pkg::CMD_READ: begin
                           addr_in  = '0;
                           phase_in = first_addr;
                        end
                        seb_pkg::CMD_WRITE: begin
                           if (wel_ff) begin
                              addr_in  = '0;
                              phase_in = first_addr;
                           end else begin
                              phase_in = seb_pkg::PH_IDLE;
                           end
                        end
                        default: ;
                     endcase
                  end
                  seb_pkg::PH_RDSR: begin
                     mreq.rsp_byte = {swd_ff, 3'b000, prot_ff, wel_ff, 1'b0};
                  end
                  seb_pkg::PH_WRSR: begin
                     wel_in   = data_byte[1];
                     prot_in  = data_byte[3:2];
                     swd_in   = data_byte[7];
                     phase_in = seb_pkg::PH_IDLE;
                  end
                  seb_pkg::PH_ADDR0: begin
                     addr_in  = {data_byte, 16'h0000};
                     phase_in = seb_pkg::PH_ADDR1;
                  end
                  seb_pkg::PH_ADDR1: begin
                     addr_in  = {addr_ff[23:16], addr_ff[15:8] | data_byte, addr_ff[7:0]};
                     phase_in = seb_pkg::PH_ADDR2;
                  end
                  seb_pkg::PH_ADDR2: begin
                     addr_in  = {addr_ff[23:8], addr_ff[7:0] | data_byte};
                     phase_in = (last_cmd_ff == seb_pkg::CMD_READ) ? seb_pkg::PH_READ
                                                                    : seb_pkg::PH_WRITE;
                  end
                  seb_pkg::PH_READ: begin
                     mreq.rd = 1'b1;
                     addr_in = addr_ff + 24'd1;
                  end
                  seb_pkg::PH_WRITE: begin
                     if (!blocked) begin
                        mreq.wr = 1'b1;
                        addr_in = (addr_ff & ~pmask) | ((addr_ff + 24'd1) & pmask);
                     end
                  end
                  default: ;
               endcase
            end
            seb_pkg::ACT_SELECT: begin
               if (phase_ff == seb_pkg::PH_DESEL) begin
                  phase_in = seb_pkg::PH_CMD;
               end
            end
            seb_pkg::ACT_RELEASE: begin
               // drop the latch after either kind of write
               if (last_cmd_ff == seb_pkg::CMD_WRITE || last_cmd_ff == seb_pkg::CMD_WRSR) begin
                  wel_in = 1'b0;
               end
               phase_in = seb_pkg::PH_DESEL;
            end
            default: ;
         endcase
      end
   end

   // Hold the command state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= seb_pkg::PH_DESEL;
         last_cmd_ff <= '0;
         addr_ff     <= '0;
         wel_ff      <= 1'b0;
         prot_ff     <= seb_pkg::PROT_NONE;
         swd_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         last_cmd_ff <= last_cmd_in;
         addr_ff     <= addr_in;
         wel_ff      <= wel_in;
         prot_ff     <= prot_in;
         swd_ff      <= swd_in;
      end
   end

   `SEB_ASSERT_NOW(a_no_write_when_locked, clock, reset, mreq.wr, prot_ff != seb_pkg::PROT_ALL, "store written while fully protected")
   `SEB_ASSERT_NEXT(a_release_deselects, clock, reset, fire && action == seb_pkg::ACT_RELEASE, phase_ff == seb_pkg::PH_DESEL, "release left the device selected")

endmodule

@@ sv/spi_eeprom_backup_device.sv @@
// SPI serial EEPROM/FRAM backup device (25xx command set), one SPI byte or chip-select
// event per transaction on req, one returned byte per transaction on rsp. A new
// transaction is taken every cycle while rsp keeps up. The store is read at the accepting
// edge alongside stage 1, and the output register loads from stage 1 once it is free, so
// the result is presented on rsp from the output register; with rsp stalled, two
// transactions are held before req.ready drops. Neither req nor csr is ready in reset.
// Store contents are undefined until written and are not cleared after reset. The user
// must write size_code through csr only while no transaction is in flight; not enforced.
`include "assert_macros.svh"

module spi_eeprom_backup_device #(
   parameter int MEM_BYTES = 131072
) (
   input logic        clock,
   input logic        reset,
   seb_req_if.sink    req,
   seb_rsp_if.source  rsp,
   seb_csr_if.sink    csr
);

   localparam int AddrWidth = $clog2(MEM_BYTES);
   localparam logic [AddrWidth-1:0] MemMask = AddrWidth'(MEM_BYTES - 1);

   logic [1:0] size_code_ff;

   logic                 req_fire;
   logic                 s2_free;
   seb_pkg::mem_req_type mreq;
   logic [AddrWidth-1:0] mem_addr;

   logic [7:0] store_mem [MEM_BYTES];
   logic [7:0] rd_data_ff;

   logic       s1_valid_ff;
   logic       s1_from_mem_ff;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;

   // Size register
   assign csr.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_code_ff <= seb_pkg::SIZE_8K;
      end else if (csr.valid) begin
         size_code_ff <= csr.size_code;
      end
   end

   // Handshake: stage 1 moves on whenever the output register is free
   assign s2_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !reset && (!s1_valid_ff || s2_free);
   assign req_fire  = req.valid && req.ready;

   seb_cmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .action    (req.action),
      .data_byte (req.data_byte),
      .size_code (size_code_ff),
      .mreq      (mreq)
   );

   assign mem_addr = mreq.index[AddrWidth-1:0] & MemMask;

   // Byte store: one access per transaction, so read and write never meet in a cycle
   always_ff @(posedge clock) begin
      if (mreq.wr) begin
         store_mem[mem_addr] <= mreq.wdata;
      end
      if (mreq.rd) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // Stage 1: wait for the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_from_mem_ff <= mreq.rd;
         s1_byte_ff     <= mreq.rsp_byte;
      end
   end

   // Stage 2: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         rsp_byte_ff <= s1_from_mem_ff ? rd_data_ff : s1_byte_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_byte = rsp_byte_ff;

   `SEB_ASSERT_NEXT(a_accept_lands, clock, reset, req_fire, s1_valid_ff, "accepted transaction lost before stage 1")
   `SEB_ASSERT_NEXT(a_stage1_drains, clock, reset, s1_valid_ff && s2_free, rsp_valid_ff, "stage 1 did not reach the output register")
   `SEB_ASSERT_NEXT(a_stage1_holds, clock, reset, s1_valid_ff && !s2_free, s1_valid_ff && $stable(s1_byte_ff) && (!s1_from_mem_ff || $stable(rd_data_ff)), "stalled stage 1 changed")

endmodule
